// ----- hw/rtl/dsfc_pkg.sv -----
// Shared types and constants of the distance sensor frame conditioner.
`default_nettype none

package dsfc_pkg;

   localparam int unsigned WORD_W  = 16;
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned DIST_W  = 21;
   localparam int unsigned MAG_W   = 20;
   localparam int unsigned CHAN_N  = 4;
   localparam int unsigned CHAN_W  = 2;
   localparam int unsigned SPAN_W  = 15;
   localparam int unsigned PROD_W  = 57;
   localparam int unsigned SHIFT   = 37;
   localparam int unsigned BOUND_W = 23;

   localparam int unsigned REQ_DATA_W = 96;
   localparam int unsigned RSP_DATA_W = 152;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [WORD_W-1:0] ADC_LOW  = 16'd700;
   localparam logic [WORD_W-1:0] ADC_HIGH = 16'd32100;
   localparam logic [WORD_W-1:0] WORD_MAX = 16'hFFFF;

   // d = floor((x*7190 + 157) / 314), done as ((x*7190 + 157) * M) >> 37
   // with M = ceil(2^37 / 314); the two products are folded into constants.
   localparam logic [PROD_W-1:0] MAP_SCALE  = 57'd3147089416060;
   localparam logic [PROD_W-1:0] MAP_OFFSET = 57'd68719476818;

   localparam logic [BOUND_W-1:0] MM_SCALE = 23'd100;

   localparam logic [DIST_W-1:0] INVALID_DIST = 21'h1E7960;

   localparam logic [WORD_W-1:0] MISS_LIMIT_RESET  = 16'd5;
   localparam logic [WORD_W-1:0] REGION_HIGH_RESET = 16'd7190;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CHAN1_ADD   = 3'd0,
      CSR_CHAN2_SUB   = 3'd1,
      CSR_CHAN3_SUB   = 3'd2,
      CSR_MISS_LIMIT  = 3'd3,
      CSR_WATCH_CHAN  = 3'd4,
      CSR_REGION_LOW  = 3'd5,
      CSR_REGION_HIGH = 3'd6,
      CSR_HOLD_TIME   = 3'd7
   } csr_index_type;

endpackage

`default_nettype wire

// ----- hw/rtl/dsfc_dist_map.sv -----
// Clamp of one stored ADC word and linear map to distance in 0.01 mm.
`default_nettype none

module dsfc_dist_map import dsfc_pkg::*; (
   input  wire logic [WORD_W-1:0] word,
   output logic      [MAG_W-1:0]  distance
);

   logic [WORD_W-1:0] clamped;
   logic [SPAN_W-1:0] span;
   logic [PROD_W-1:0] prod;

   always_comb begin
      if (word < ADC_LOW) begin
         clamped = ADC_LOW;
      end else if (word > ADC_HIGH) begin
         clamped = ADC_HIGH;
      end else begin
         clamped = word;
      end
      span     = SPAN_W'(clamped - ADC_LOW);
      prod     = PROD_W'(span) * MAP_SCALE + MAP_OFFSET;
      distance = prod[SHIFT +: MAG_W];
   end

endmodule

`default_nettype wire

// ----- hw/rtl/distance_sensor_frame_conditioner.sv -----
// Top level of the distance sensor frame conditioner.
//
//   channel | direction | transfer carries
//   --------+-----------+--------------------------------------------------
//   req_    | in        | one update tick: frame flag, four raw words, time
//   rsp_    | out       | four distances, miss status, region detector
//   csr_    | in        | register index and write data
//
// One tick per cycle sustained while rsp_tready is held high; a result passes the
// stage register and then the result register. The request edge updates the stored
// words and the miss counter; when the stage advances, all four channels are mapped
// and the region detector runs. Reset sets every register but stage_now_ff and
// rsp_data_ff to its documented reset value. A stalled result holds; req_tready
// drops only while both stages are full and the result is not taken.
`default_nettype none

module distance_sensor_frame_conditioner import dsfc_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // word_zero, word_one, word_two, word_three, now_ms
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // frame_present
   input  wire logic                  req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // dist_zero, dist_one, dist_two, dist_three, all_valid, misses,
   // watched_raw, zone_hit, detected, region_since_ms, zero pad
   output logic      [RSP_DATA_W-1:0] rsp_tdata,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [WORD_W-1:0] chan1_add_ff, chan1_add_in;
   logic [WORD_W-1:0] chan2_sub_ff, chan2_sub_in;
   logic [WORD_W-1:0] chan3_sub_ff, chan3_sub_in;
   logic [WORD_W-1:0] miss_limit_ff, miss_limit_in;
   logic [CHAN_W-1:0] watch_ff, watch_in;
   logic [WORD_W-1:0] region_low_ff, region_low_in;
   logic [WORD_W-1:0] region_high_ff, region_high_in;
   logic [TIME_W-1:0] hold_time_ff, hold_time_in;

   logic [WORD_W-1:0] raw_store_ff [CHAN_N];
   logic [WORD_W-1:0] raw_store_in [CHAN_N];
   logic [WORD_W-1:0] miss_ff, miss_in;
   logic              stage_valid_ff, stage_valid_in;
   logic [TIME_W-1:0] stage_now_ff, stage_now_in;
   logic              was_in_region_ff, was_in_region_in;
   logic [TIME_W-1:0] spell_start_ff, spell_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic              req_xfer;
   logic              out_advance;
   logic              stage_advance;
   logic [WORD_W-1:0] word_in [CHAN_N];
   logic [WORD_W:0]   chan1_sum;
   logic [MAG_W-1:0]  map_dist [CHAN_N];
   logic [DIST_W-1:0] dist_out [CHAN_N];
   logic              all_valid;
   logic [MAG_W-1:0]  watched_dist;
   logic [BOUND_W-1:0] low_bound;
   logic [BOUND_W-1:0] high_bound;
   logic              zone_hit;
   logic              was_next;
   logic [TIME_W-1:0] spell_next;
   logic [TIME_W-1:0] elapsed;
   logic              detected;

   assign csr_ready   = 1'b1;
   assign out_advance = !rsp_valid_ff || rsp_tready;
   assign stage_advance = stage_valid_ff && out_advance;
   assign req_tready  = !stage_valid_ff || out_advance;
   assign req_xfer    = req_tvalid && req_tready;
   assign rsp_tvalid  = rsp_valid_ff;
   assign rsp_tdata   = rsp_data_ff;

   always_comb begin
      chan1_add_in   = chan1_add_ff;
      chan2_sub_in   = chan2_sub_ff;
      chan3_sub_in   = chan3_sub_ff;
      miss_limit_in  = miss_limit_ff;
      watch_in       = watch_ff;
      region_low_in  = region_low_ff;
      region_high_in = region_high_ff;
      hold_time_in   = hold_time_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_CHAN1_ADD:   chan1_add_in   = csr_wdata[WORD_W-1:0];
            CSR_CHAN2_SUB:   chan2_sub_in   = csr_wdata[WORD_W-1:0];
            CSR_CHAN3_SUB:   chan3_sub_in   = csr_wdata[WORD_W-1:0];
            CSR_MISS_LIMIT:  miss_limit_in  = csr_wdata[WORD_W-1:0];
            CSR_WATCH_CHAN:  watch_in       = csr_wdata[CHAN_W-1:0];
            CSR_REGION_LOW:  region_low_in  = csr_wdata[WORD_W-1:0];
            CSR_REGION_HIGH: region_high_in = csr_wdata[WORD_W-1:0];
            CSR_HOLD_TIME:   hold_time_in   = csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   // Adjust the incoming words and update the store and miss counter.
   always_comb begin
      word_in[0] = req_tdata[0*WORD_W +: WORD_W];
      word_in[1] = req_tdata[1*WORD_W +: WORD_W];
      word_in[2] = req_tdata[2*WORD_W +: WORD_W];
      word_in[3] = req_tdata[3*WORD_W +: WORD_W];
      chan1_sum  = {1'b0, word_in[1]} + {1'b0, chan1_add_ff};

      raw_store_in   = raw_store_ff;
      miss_in        = miss_ff;
      stage_now_in   = stage_now_ff;
      stage_valid_in = stage_valid_ff;
      if (stage_advance) begin
         stage_valid_in = 1'b0;
      end
      if (req_xfer) begin
         stage_valid_in = 1'b1;
         stage_now_in   = req_tdata[CHAN_N*WORD_W +: TIME_W];
         if (req_tuser) begin
            raw_store_in[0] = word_in[0];
            raw_store_in[1] = chan1_sum[WORD_W] ? WORD_MAX : chan1_sum[WORD_W-1:0];
            raw_store_in[2] = (word_in[2] > chan2_sub_ff) ? word_in[2] - chan2_sub_ff
                                                          : '0;
            raw_store_in[3] = (word_in[3] > chan3_sub_ff) ? word_in[3] - chan3_sub_ff
                                                          : '0;
            miss_in = '0;
         end else if (miss_ff != WORD_MAX) begin
            miss_in = miss_ff + 1'b1;
         end
      end
   end

   for (genvar k = 0; k < CHAN_N; k++) begin : g_map
      dsfc_dist_map u_map (
         .word     (raw_store_ff[k]),
         .distance (map_dist[k])
      );
   end

   // Validity, region test and spell tracking.
   always_comb begin
      all_valid = miss_ff < miss_limit_ff;
      for (int k = 0; k < CHAN_N; k++) begin
         dist_out[k] = all_valid ? {1'b0, map_dist[k]} : INVALID_DIST;
      end
      watched_dist = map_dist[watch_ff];
      low_bound    = BOUND_W'(region_low_ff) * MM_SCALE;
      high_bound   = BOUND_W'(region_high_ff) * MM_SCALE;
      zone_hit = all_valid
              && (BOUND_W'(watched_dist) >= low_bound)
              && (BOUND_W'(watched_dist) <= high_bound);

      was_next   = was_in_region_ff;
      spell_next = spell_start_ff;
      if (zone_hit != was_in_region_ff) begin
         was_next   = zone_hit;
         spell_next = zone_hit ? stage_now_ff : '0;
      end else if (zone_hit && (spell_start_ff == '0)) begin
         spell_next = stage_now_ff;
      end
      elapsed  = stage_now_ff - spell_next;
      detected = zone_hit && ((hold_time_ff == '0) || (elapsed >= hold_time_ff));

      was_in_region_in = stage_advance ? was_next : was_in_region_ff;
      spell_start_in   = stage_advance ? spell_next : spell_start_ff;

      rsp_data_in = rsp_data_ff;
      if (stage_advance) begin
         rsp_data_in = {1'b0, spell_next, detected, zone_hit, raw_store_ff[watch_ff],
                        miss_ff, all_valid, dist_out[3], dist_out[2], dist_out[1],
                        dist_out[0]};
      end

      rsp_valid_in = rsp_valid_ff;
      if (stage_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan1_add_ff     <= '0;
         chan2_sub_ff     <= '0;
         chan3_sub_ff     <= '0;
         miss_limit_ff    <= MISS_LIMIT_RESET;
         watch_ff         <= '0;
         region_low_ff    <= '0;
         region_high_ff   <= REGION_HIGH_RESET;
         hold_time_ff     <= '0;
         for (int k = 0; k < CHAN_N; k++) begin
            raw_store_ff[k] <= '0;
         end
         miss_ff          <= '0;
         stage_valid_ff   <= 1'b0;
         was_in_region_ff <= 1'b0;
         spell_start_ff   <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         chan1_add_ff     <= chan1_add_in;
         chan2_sub_ff     <= chan2_sub_in;
         chan3_sub_ff     <= chan3_sub_in;
         miss_limit_ff    <= miss_limit_in;
         watch_ff         <= watch_in;
         region_low_ff    <= region_low_in;
         region_high_ff   <= region_high_in;
         hold_time_ff     <= hold_time_in;
         raw_store_ff     <= raw_store_in;
         miss_ff          <= miss_in;
         stage_valid_ff   <= stage_valid_in;
         was_in_region_ff <= was_in_region_in;
         spell_start_ff   <= spell_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      stage_now_ff <= stage_now_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ----- verif/distance_sensor_frame_conditioner_tb.sv -----
// Self-checking testbench for the distance sensor frame conditioner: directed and random ticks.
`default_nettype none

module distance_sensor_frame_conditioner_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import dsfc_pkg::*;

   localparam longint unsigned RAW_MIN    = 700;
   localparam longint unsigned RAW_MAX    = 32100;
   localparam longint unsigned FULL_SCALE = 719000;
   localparam longint unsigned RAW_SPAN   = 31400;
   localparam logic [20:0]     DIST_NONE  = 21'(-100000);
   localparam int              WATCHDOG_LIMIT = 2000;
   localparam int              PRINT_LIMIT    = 40;

   typedef struct packed {
      logic [31:0]      now_ms;
      logic [3:0][15:0] words;
   } tick_data_type;

   typedef struct packed {
      logic          frame;
      tick_data_type data;
   } tick_type;

   typedef struct packed {
      logic             pad;
      logic [31:0]      since_ms;
      logic             detected;
      logic             zone_hit;
      logic [15:0]      watched_raw;
      logic [15:0]      misses;
      logic             all_valid;
      logic [3:0][20:0] distance;
   } reading_type;

   typedef struct packed {
      csr_index_type idx;
      logic [31:0]   value;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   csr_index_type csr_index = CSR_CHAN1_ADD;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor configuration and state
   logic [15:0] ch1_add = 16'd0;
   logic [15:0] ch2_sub = 16'd0;
   logic [15:0] ch3_sub = 16'd0;
   logic [15:0] miss_limit = 16'd5;
   logic [1:0]  watch = 2'd0;
   logic [15:0] low_mm = 16'd0;
   logic [15:0] high_mm = 16'd7190;
   logic [31:0] hold_ms = 32'd0;
   logic [3:0][15:0] stored = '0;
   logic [15:0] miss_n = 16'd0;
   logic        in_spell = 1'b0;
   logic [31:0] spell_ms = 32'd0;

   tick_type      pending_ticks[$];
   reading_type   expected_readings[$];
   reg_write_type pending_writes[$];

   int unsigned ticks_queued = 0;
   int unsigned ticks_sent = 0;
   int unsigned writes_queued = 0;
   int unsigned writes_done = 0;
   int unsigned readings_seen = 0;
   int unsigned mismatches = 0;
   int unsigned quiet_cycles = 0;
   int          gap_left = 0;
   int          stall_left = 0;
   bit          idle_on = 1'b1;
   logic [31:0] sim_ms = 32'd0;
   int          level[4] = '{default: 16000};

   distance_sensor_frame_conditioner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [20:0] to_distance(logic [15:0] w);
      longint unsigned v;
      v = w;
      if (v < RAW_MIN) v = RAW_MIN;
      if (v > RAW_MAX) v = RAW_MAX;
      return 21'(((v - RAW_MIN) * FULL_SCALE + RAW_SPAN / 2) / RAW_SPAN);
   endfunction

   function automatic reading_type condition_tick(tick_type t);
      reading_type r;
      logic [16:0] sum;
      logic        ok;
      logic        hit;
      int          d;
      int          k;
      r = '0;
      if (t.frame) begin
         sum = {1'b0, t.data.words[1]} + {1'b0, ch1_add};
         stored[0] = t.data.words[0];
         stored[1] = sum[16] ? 16'hFFFF : sum[15:0];
         stored[2] = (t.data.words[2] > ch2_sub) ? t.data.words[2] - ch2_sub : 16'd0;
         stored[3] = (t.data.words[3] > ch3_sub) ? t.data.words[3] - ch3_sub : 16'd0;
         miss_n = 16'd0;
      end else if (miss_n != 16'hFFFF) begin
         miss_n = miss_n + 16'd1;
      end
      ok = miss_n < miss_limit;
      for (k = 0; k < 4; k++) begin
         r.distance[k] = ok ? to_distance(stored[k]) : DIST_NONE;
      end
      d = int'(to_distance(stored[watch]));
      hit = ok && d >= int'(low_mm) * 100 && d <= int'(high_mm) * 100;
      if (hit != in_spell) begin
         in_spell = hit;
         spell_ms = hit ? t.data.now_ms : 32'd0;
      end else if (hit && spell_ms == 32'd0) begin
         spell_ms = t.data.now_ms;
      end
      r.all_valid   = ok;
      r.misses      = miss_n;
      r.watched_raw = stored[watch];
      r.zone_hit    = hit;
      r.detected    = hit && (hold_ms == 32'd0 || (t.data.now_ms - spell_ms) >= hold_ms);
      r.since_ms    = spell_ms;
      return r;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT) begin
         $display("mismatch on reading %0d, %s: got %0h, expected %0h",
                  readings_seen, field, got, want);
      end
   endtask

   // driver: request channel
   always @(posedge clock) begin : driver
      tick_type t;
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left   <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_readings.push_back(condition_tick(tick_type'({req_tuser, req_tdata})));
            ticks_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left   <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (idle_on && pending_ticks.size() > 0 && $urandom_range(0, 7) == 0) begin
               gap_left   <= $urandom_range(0, 4);
               req_tvalid <= 1'b0;
            end else if (pending_ticks.size() > 0) begin
               t = pending_ticks.pop_front();
               req_tuser  <= t.frame;
               req_tdata  <= t.data;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: result channel
   always @(posedge clock) begin : monitor
      reading_type got;
      reading_type want;
      int          k;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = reading_type'(rsp_tdata);
            if (expected_readings.size() == 0) begin
               report_mismatch("reading with nothing expected", got.misses, '0);
            end else begin
               want = expected_readings.pop_front();
               for (k = 0; k < 4; k++) begin
                  if (got.distance[k] !== want.distance[k]) begin
                     report_mismatch($sformatf("distance %0d", k), got.distance[k],
                                     want.distance[k]);
                  end
               end
               if (got.all_valid !== want.all_valid) begin
                  report_mismatch("all_valid", got.all_valid, want.all_valid);
               end
               if (got.misses !== want.misses) begin
                  report_mismatch("misses", got.misses, want.misses);
               end
               if (got.watched_raw !== want.watched_raw) begin
                  report_mismatch("watched_raw", got.watched_raw, want.watched_raw);
               end
               if (got.zone_hit !== want.zone_hit) begin
                  report_mismatch("zone_hit", got.zone_hit, want.zone_hit);
               end
               if (got.detected !== want.detected) begin
                  report_mismatch("detected", got.detected, want.detected);
               end
               if (got.since_ms !== want.since_ms) begin
                  report_mismatch("region_since_ms", got.since_ms, want.since_ms);
               end
            end
            readings_seen++;
         end
         if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left <= $urandom_range(0, 4);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // register port
   always @(posedge clock) begin : reg_port
      reg_write_type w;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_CHAN1_ADD:   ch1_add    = csr_wdata[15:0];
               CSR_CHAN2_SUB:   ch2_sub    = csr_wdata[15:0];
               CSR_CHAN3_SUB:   ch3_sub    = csr_wdata[15:0];
               CSR_MISS_LIMIT:  miss_limit = csr_wdata[15:0];
               CSR_WATCH_CHAN:  watch      = csr_wdata[1:0];
               CSR_REGION_LOW:  low_mm     = csr_wdata[15:0];
               CSR_REGION_HIGH: high_mm    = csr_wdata[15:0];
               CSR_HOLD_TIME:   hold_ms    = csr_wdata;
               default: ;
            endcase
            writes_done++;
         end
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() > 0) begin
               w = pending_writes.pop_front();
               csr_index <= w.idx;
               csr_wdata <= w.value;
               csr_valid <= 1'b1;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
                   (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic queue_tick(logic frame, logic [3:0][15:0] w, logic [31:0] now);
      tick_type t;
      t.frame       = frame;
      t.data.words  = w;
      t.data.now_ms = now;
      pending_ticks.push_back(t);
      ticks_queued++;
   endtask

   task automatic queue_write(csr_index_type idx, logic [31:0] value);
      reg_write_type w;
      w.idx   = idx;
      w.value = value;
      pending_writes.push_back(w);
      writes_queued++;
   endtask

   // hold until every transfer is done and the pipeline is empty
   task automatic drain();
      while (ticks_sent != ticks_queued || expected_readings.size() != 0 ||
             writes_done != writes_queued) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [31:0] with_noise(logic [15:0] v);
      return {16'($urandom()), v};
   endfunction

   function automatic logic [15:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 16'($urandom_range(0, 800));
         1: return 16'($urandom_range(31900, 32300));
         2: return 16'hFFFF;
         3: return 16'h0000;
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [31:0] offset_value();
      case ($urandom_range(0, 5))
         0: return with_noise(16'h0000);
         1: return with_noise(16'hFFFF);
         2: return $urandom();
         default: return with_noise(16'($urandom_range(0, 3000)));
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [15:0]      lo;
      logic [15:0]      hi;
      logic [31:0]      limit;
      logic [31:0]      hold;
      logic [3:0][15:0] w;
      logic             frame;
      int               miss_run;
      int               v;
      int               k;
      int               n;
      drain();
      case ($urandom_range(0, 7))
         0: begin lo = 16'd0; hi = 16'hFFFF; end
         1: begin lo = 16'($urandom_range(1000, 7190)); hi = 16'($urandom_range(0, lo - 1)); end
         2: begin lo = 16'hFFFF; hi = 16'hFFFF; end
         default: begin
            lo = 16'($urandom_range(0, 6500));
            hi = lo + 16'($urandom_range(0, 2500));
         end
      endcase
      case ($urandom_range(0, 7))
         0: limit = with_noise(16'h0000);
         1: limit = with_noise(16'hFFFF);
         2: limit = $urandom();
         default: limit = with_noise(16'($urandom_range(1, 10)));
      endcase
      case ($urandom_range(0, 7))
         0, 1: hold = 32'd0;
         2: hold = 32'hFFFF_FFFF;
         3: hold = $urandom();
         default: hold = $urandom_range(1, 40);
      endcase
      queue_write(CSR_CHAN1_ADD, offset_value());
      queue_write(CSR_CHAN2_SUB, offset_value());
      queue_write(CSR_CHAN3_SUB, offset_value());
      queue_write(CSR_MISS_LIMIT, limit);
      queue_write(CSR_WATCH_CHAN, $urandom());
      queue_write(CSR_REGION_LOW, with_noise(lo));
      queue_write(CSR_REGION_HIGH, with_noise(hi));
      queue_write(CSR_HOLD_TIME, hold);
      drain();
      miss_run = 0;
      for (n = 0; n < count; n++) begin
         if (miss_run > 0) begin
            frame = 1'b0;
            miss_run--;
         end else if ($urandom_range(0, 19) == 0) begin
            frame = 1'b0;
            miss_run = $urandom_range(0, 8);
         end else begin
            frame = 1'b1;
         end
         for (k = 0; k < 4; k++) begin
            if ($urandom_range(0, 15) == 0) begin
               level[k] = pick_word();
            end else begin
               v = level[k] + int'($urandom_range(0, 300)) - 150;
               level[k] = (v < 0) ? 0 : (v > 65535) ? 65535 : v;
            end
            w[k] = frame ? 16'(level[k]) : 16'($urandom());
         end
         case ($urandom_range(0, 99))
            0: sim_ms = $urandom();
            1: sim_ms = 32'hFFFF_FFF0 + $urandom_range(0, 15);
            2: sim_ms = 32'd0;
            default: sim_ms = sim_ms + $urandom_range(0, 3);
         endcase
         queue_tick(frame, w, sim_ms);
      end
   endtask

   initial begin : stimulus
      int n;
      reset = 1'b1;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: clamp edges, spell from time zero, miss limit, time wrap
      queue_tick(1'b1, {16'd0, 16'd0, 16'd0, 16'd0}, 32'd0);
      queue_tick(1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 32'd1);
      queue_tick(1'b1, {16'd32101, 16'd699, 16'd32100, 16'd700}, 32'd2);
      queue_tick(1'b1, {16'd16400, 16'd15700, 16'd32099, 16'd701}, 32'd3);
      for (n = 0; n < 6; n++) begin
         queue_tick(1'b0, {16'hFFFF, 16'h0000, 16'hAAAA, 16'h5555}, 32'd4 + n);
      end
      queue_tick(1'b1, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 32'hFFFF_FFFF);
      queue_tick(1'b1, {16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0}, 32'd0);

      // extreme settings: saturating offsets, zero miss limit
      drain();
      queue_write(CSR_CHAN1_ADD, 32'h0000_FFFF);
      queue_write(CSR_CHAN2_SUB, 32'h0000_FFFF);
      queue_write(CSR_CHAN3_SUB, 32'h0000_FFFF);
      queue_write(CSR_MISS_LIMIT, 32'h0000_0000);
      queue_write(CSR_WATCH_CHAN, 32'd3);
      queue_write(CSR_REGION_LOW, 32'h0000_FFFF);
      queue_write(CSR_REGION_HIGH, 32'h0000_FFFF);
      queue_write(CSR_HOLD_TIME, 32'hFFFF_FFFF);
      drain();
      queue_tick(1'b1, {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, 32'd50);
      queue_tick(1'b1, {16'd0, 16'd0, 16'd0, 16'd0}, 32'd51);
      queue_tick(1'b1, {16'd32100, 16'd700, 16'd1, 16'hFFFE}, 32'd52);

      // empty region, small offsets, largest miss limit
      drain();
      queue_write(CSR_CHAN1_ADD, 32'd1);
      queue_write(CSR_CHAN2_SUB, 32'd1);
      queue_write(CSR_CHAN3_SUB, 32'd1);
      queue_write(CSR_MISS_LIMIT, 32'h0000_FFFF);
      queue_write(CSR_WATCH_CHAN, 32'd1);
      queue_write(CSR_REGION_LOW, 32'd3000);
      queue_write(CSR_REGION_HIGH, 32'd1000);
      queue_write(CSR_HOLD_TIME, 32'd10);
      drain();
      queue_tick(1'b1, {16'd0, 16'hFFFE, 16'd1, 16'd1}, 32'd60);
      queue_tick(1'b1, {16'hFFFF, 16'd2, 16'd2, 16'd2}, 32'd61);

      // hold time reached on a steady channel
      drain();
      queue_write(CSR_REGION_LOW, 32'd0);
      queue_write(CSR_REGION_HIGH, 32'd7190);
      queue_write(CSR_HOLD_TIME, 32'd3);
      queue_write(CSR_WATCH_CHAN, 32'd2);
      drain();
      for (n = 0; n < 6; n++) begin
         queue_tick(1'b1, {16'd16000, 16'd16000, 16'd16000, 16'd16000}, 32'd100 + n);
      end

      for (n = 0; n < 9; n++) begin
         idle_on = (n != 4);
         random_phase(120);
      end

      // long miss run across the miss limit
      idle_on = 1'b0;
      drain();
      queue_write(CSR_MISS_LIMIT, 32'd30);
      drain();
      for (n = 0; n < 40; n++) begin
         sim_ms = sim_ms + 32'd1;
         queue_tick(1'b0, {16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom())},
                    sim_ms);
      end
      queue_tick(1'b1, {16'd20000, 16'd20000, 16'd20000, 16'd20000}, sim_ms + 32'd1);

      random_phase(120);
      drain();

      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
